// File: rtl/periodic_minimum_image_fold_unit_assert.svh
// Assertion macros for the periodic image fold RTL
`ifndef PERIODIC_MINIMUM_IMAGE_FOLD_UNIT_ASSERT_SVH
`define PERIODIC_MINIMUM_IMAGE_FOLD_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PMIF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PMIF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pmif_pkg.sv
// Types and constants for the periodic image fold unit
package pmif_pkg;

    localparam int ELEM_BITS = 21;
    localparam int WORD_BITS = 63;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_CUBIC = 2'd1;
    localparam logic [1:0] KIND_ORTHO = 2'd2;
    localparam logic [1:0] KIND_PARA  = 2'd3;

    localparam logic [1:0] FUNC_MIN_VEC = 2'd0;
    localparam logic [1:0] FUNC_MIN_POS = 2'd1;
    localparam logic [1:0] FUNC_FOLD    = 2'd2;

    localparam logic [2:0] REG_FRAME_KIND   = 3'd0;
    localparam logic [2:0] REG_EDGE_LENGTHS = 3'd1;
    localparam logic [2:0] REG_AXIS_A       = 3'd2;
    localparam logic [2:0] REG_AXIS_B       = 3'd3;
    localparam logic [2:0] REG_AXIS_C       = 3'd4;
    localparam logic [2:0] REG_INV_COL_0    = 3'd5;
    localparam logic [2:0] REG_INV_COL_1    = 3'd6;
    localparam logic [2:0] REG_INV_COL_2    = 3'd7;

    typedef logic signed [ELEM_BITS-1:0] elem_t;

    // axes[k][i]: component i of axis k; inv[j][i]: row i of inverse column j
    typedef struct packed {
        logic [1:0]         kind;
        elem_t [2:0]        lengths;
        elem_t [2:0][2:0]   axes;
        elem_t [2:0][2:0]   inv;
    } frame_cfg_t;

    function automatic elem_t word_elem(input logic [WORD_BITS-1:0] w, input int unsigned k);
        return w[k*ELEM_BITS +: ELEM_BITS];
    endfunction

endpackage

// File: rtl/pmif_frac_path.sv
// Parallelepiped path: fractional transform, wrap and back-transform, four stages
module pmif_frac_path
    import pmif_pkg::*;
#(
    parameter int COORD_BITS      = 32,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  adv,
    input  frame_cfg_t                            frame,
    input  logic                                  fold_in,
    input  logic [2:0][COORD_BITS:0]              d_in,
    input  logic [2:0][COORD_BITS-1:0]            r1_in,
    output logic [2:0][COORD_FRAC_BITS+13:0]      v_out,
    output logic                                  inside_out
);

    localparam int DW  = COORD_BITS + 1;
    localparam int MW  = DW + ELEM_BITS;
    localparam int PW  = DW + 10;
    localparam int FW  = DW + 12;
    localparam int UB  = COORD_FRAC_BITS + 8;
    localparam int WW  = UB + 1;
    localparam int AW  = WW + ELEM_BITS;
    localparam int SW  = AW + 2;
    localparam int PVW = COORD_FRAC_BITS + 14;

    localparam logic [FW-1:0]        UNIT_F     = FW'(1) << UB;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(131072);

    logic signed [MW-1:0] pd_full [3][3];
    logic signed [MW-1:0] pr_full [3][3];
    logic signed [PW-1:0] pd_reg  [3][3];
    logic signed [PW-1:0] pr_reg  [3][3];
    logic                 fold_q1_reg;

    logic signed [FW-1:0] fd_sum [3];
    logic signed [FW-1:0] fr_sum [3];
    logic signed [WW-1:0] w_reg  [3];
    logic signed [FW-1:0] fr1_reg [3];

    logic signed [AW-1:0] p3_full [3][3];
    logic signed [AW-1:0] p3_reg  [3][3];
    logic                 inside_q3_reg;

    logic signed [SW-1:0] s_sum [3];
    logic [2:0][PVW-1:0]  v_reg;
    logic                 inside_q4_reg;
    logic                 inside_q3_next;

    // stage 1: component times inverse element, floored to F+8 fraction bits
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                pd_full[j][i] = $signed(d_in[j]) * $signed(frame.inv[j][i]);
                pr_full[j][i] = $signed({r1_in[j][COORD_BITS-1], r1_in[j]})
                                * $signed(frame.inv[j][i]);
            end
        end
    end

    // stage 2: fractional sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fd_sum[i] = FW'(pd_reg[0][i]) + FW'(pd_reg[1][i]) + FW'(pd_reg[2][i]);
            fr_sum[i] = FW'(pr_reg[0][i]) + FW'(pr_reg[1][i]) + FW'(pr_reg[2][i]);
        end
    end

    // stage 3: back to cartesian
    always_comb begin
        inside_q3_next = 1'b1;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                p3_full[k][i] = $signed(frame.axes[k][i]) * w_reg[k];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (fr1_reg[i][FW-1] || (fr1_reg[i] > UNIT_F)) begin
                inside_q3_next = 1'b0;
            end
        end
    end

    // stage 4: exact sum, rounded to coordinate units
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_sum[i] = SW'(p3_reg[0][i]) + SW'(p3_reg[1][i]) + SW'(p3_reg[2][i])
                       + ROUND_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fold_q1_reg <= fold_in;
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    pd_reg[j][i] <= pd_full[j][i][MW-1:11];
                    pr_reg[j][i] <= pr_full[j][i][MW-1:11];
                    p3_reg[j][i] <= p3_full[j][i];
                end
            end
            for (int i = 0; i < 3; i++) begin
                // minimum image keeps the signed low bits, fold the unsigned ones
                w_reg[i]   <= fold_q1_reg ? {1'b0, fd_sum[i][UB-1:0]}
                                          : {fd_sum[i][UB-1], fd_sum[i][UB-1:0]};
                fr1_reg[i] <= fr_sum[i];
                v_reg[i]   <= s_sum[i][SW-1:18];
            end
            inside_q3_reg <= inside_q3_next;
            inside_q4_reg <= inside_q3_reg;
        end
    end

    assign v_out      = v_reg;
    assign inside_out = inside_q4_reg;

endmodule

// File: rtl/periodic_minimum_image_fold_unit.sv
// Top level of the periodic boundary minimum-image and fold unit
//
// Input stream: s_tuser carries func, s_tdata carries r1 and r2 coordinates.
// Output stream: m_tdata carries the result vector, first_inside and saturated.
// The user must write cell setup via cfg_wr_en/cfg_index/cfg_wr_data
// only while idle; the block itself does not enforce this.
// One transfer is taken every cycle when the output side keeps up.
// The per-axis wrap has N remainder stages (one quotient bit per stage), where
// N = max(COORD_BITS+13, COORD_FRAC_BITS+22) - COORD_FRAC_BITS.
// The parallelepiped path takes four stages and is delayed to line up.
// The whole pipeline advances together: while m_tvalid is high and m_tready
// is low, every stage holds and s_tready is low; nothing is dropped.
// Reset clears all stage valid bits and the cell registers (no cell).
`include "periodic_minimum_image_fold_unit_assert.svh"

module periodic_minimum_image_fold_unit
    import pmif_pkg::*;
#(
    parameter int COORD_BITS      = 32,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]           s_tdata,
    // func
    input  logic [1:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // out_x, out_y, out_z, first_inside, saturated
    output logic [((3*COORD_BITS+2+7)/8)*8-1:0]         m_tdata,
    input  logic                                        cfg_wr_en,
    input  logic [2:0]                                  cfg_index,
    input  logic [WORD_BITS-1:0]                        cfg_wr_data
);

    localparam int CB   = COORD_BITS;
    localparam int F    = COORD_FRAC_BITS;
    localparam int DW   = CB + 1;
    localparam int OW   = ((DW + 12 > F + 22) ? DW + 12 : F + 22) + 1;
    localparam int N    = OW - 1 - F;
    localparam int PVW  = F + 14;
    localparam int IW   = ((CB + 11 > F + 22) ? CB + 11 : F + 22);
    localparam int JOIN = 6;
    localparam int STEP_END = N + 3;
    localparam int LAST = N + 6;
    localparam int OUT_BITS = 3*CB + 2;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OW-1:0]        HALF_LSB = OW'(512);
    localparam logic [OW-1:0]        ONE_LSB  = OW'(1024);
    localparam logic signed [CB-1:0] C_MAX    = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN    = {1'b1, {(CB-1){1'b0}}};

    typedef struct packed {
        logic                  fold;
        logic                  func1;
        logic [2:0][CB-1:0]    r1;
        logic [2:0][CB-1:0]    r2;
        logic [2:0][DW-1:0]    d;
        logic [2:0][OW-1:0]    rem;
        logic [2:0][OW-1:0]    m;
        logic [2:0]            neg;
        logic                  in_cell;
        logic [2:0][PVW-1:0]   pv;
        logic [2:0][CB-1:0]    res;
        logic                  sat;
    } pipe_t;

    frame_cfg_t          frame_reg, frame_next;
    pipe_t               pipe_reg  [LAST+1];
    pipe_t               pipe_next [LAST+1];
    logic [LAST:0]       valid_reg, valid_next;
    logic                adv;
    logic [2:0][PVW-1:0] frac_v;
    logic                frac_inside;

    // ---- configuration ----
    always_comb begin
        frame_next = frame_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_KIND:   frame_next.kind = cfg_wr_data[1:0];
                REG_EDGE_LENGTHS: for (int k = 0; k < 3; k++)
                                      frame_next.lengths[k] = word_elem(cfg_wr_data, k);
                REG_AXIS_A:       for (int k = 0; k < 3; k++)
                                      frame_next.axes[0][k] = word_elem(cfg_wr_data, k);
                REG_AXIS_B:       for (int k = 0; k < 3; k++)
                                      frame_next.axes[1][k] = word_elem(cfg_wr_data, k);
                REG_AXIS_C:       for (int k = 0; k < 3; k++)
                                      frame_next.axes[2][k] = word_elem(cfg_wr_data, k);
                REG_INV_COL_0:    for (int k = 0; k < 3; k++)
                                      frame_next.inv[0][k] = word_elem(cfg_wr_data, k);
                REG_INV_COL_1:    for (int k = 0; k < 3; k++)
                                      frame_next.inv[1][k] = word_elem(cfg_wr_data, k);
                REG_INV_COL_2:    for (int k = 0; k < 3; k++)
                                      frame_next.inv[2][k] = word_elem(cfg_wr_data, k);
                default: begin
                end
            endcase
        end
    end

    // ---- flow control: all stages move together ----
    assign adv        = !valid_reg[LAST] || m_tready;
    assign s_tready   = adv;
    assign valid_next = {valid_reg[LAST-1:0], s_tvalid};

    // stage 0: input register
    always_comb begin
        pipe_next[0]       = '0;
        pipe_next[0].fold  = (s_tuser != FUNC_MIN_VEC) && (s_tuser != FUNC_MIN_POS);
        pipe_next[0].func1 = (s_tuser == FUNC_MIN_POS);
        for (int a = 0; a < 3; a++) begin
            pipe_next[0].r1[a] = s_tdata[a*CB +: CB];
            pipe_next[0].r2[a] = s_tdata[(a+3)*CB +: CB];
        end
    end

    // stage 1: difference vector, box inside test
    always_comb begin : st1
        logic signed [IW-1:0] big;
        logic signed [IW-1:0] lp;
        pipe_next[1]         = pipe_reg[0];
        pipe_next[1].in_cell = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (pipe_reg[0].fold) begin
                pipe_next[1].d[a] = DW'($signed(pipe_reg[0].r1[a]));
            end else if (pipe_reg[0].func1) begin
                pipe_next[1].d[a] = DW'($signed(pipe_reg[0].r1[a]))
                                    - DW'($signed(pipe_reg[0].r2[a]));
            end else begin
                pipe_next[1].d[a] = DW'($signed(pipe_reg[0].r2[a]))
                                    - DW'($signed(pipe_reg[0].r1[a]));
            end
            big = IW'($signed({pipe_reg[0].r1[a], 10'b0}));
            lp  = IW'($signed({frame_reg.lengths[a], {F{1'b0}}}));
            if (big[IW-1] || (big > lp)) begin
                pipe_next[1].in_cell = 1'b0;
            end
        end
    end

    // stage 2: dividend and modulus per axis
    always_comb begin : st2
        logic signed [OW-1:0] lp;
        logic signed [OW-1:0] dd;
        pipe_next[2] = pipe_reg[1];
        for (int a = 0; a < 3; a++) begin
            lp = OW'($signed({frame_reg.lengths[a], {F{1'b0}}}));
            dd = OW'($signed({pipe_reg[1].d[a], 10'b0}));
            if (pipe_reg[1].fold) begin
                pipe_next[2].rem[a] = dd;
                pipe_next[2].m[a]   = lp;
            end else begin
                pipe_next[2].rem[a] = (dd <<< 1) + lp;
                pipe_next[2].m[a]   = lp <<< 1;
            end
        end
    end

    // stage 3: magnitude of the dividend
    always_comb begin
        pipe_next[3] = pipe_reg[2];
        for (int a = 0; a < 3; a++) begin
            pipe_next[3].neg[a] = pipe_reg[2].rem[a][OW-1];
            pipe_next[3].rem[a] = pipe_reg[2].rem[a][OW-1] ? -pipe_reg[2].rem[a]
                                                           : pipe_reg[2].rem[a];
        end
    end

    // remainder chain, one quotient bit per stage, high bit first
    for (genvar g = 0; g < N; g++) begin : g_step
        localparam int K = N - 1 - g;
        always_comb begin
            pipe_next[4+g] = pipe_reg[3+g];
            for (int a = 0; a < 3; a++) begin
                if ((pipe_reg[3+g].rem[a] >> K) >= pipe_reg[3+g].m[a]) begin
                    pipe_next[4+g].rem[a] = pipe_reg[3+g].rem[a]
                                            - (pipe_reg[3+g].m[a] << K);
                end
            end
            if (4 + g == JOIN) begin
                // parallelepiped results arrive here
                pipe_next[4+g].pv      = frac_v;
                pipe_next[4+g].in_cell = (frame_reg.kind == KIND_PARA) ? frac_inside
                                                                      : pipe_reg[3+g].in_cell;
            end
        end
    end

    // floored remainder for a negative dividend
    always_comb begin
        pipe_next[N+4] = pipe_reg[N+3];
        for (int a = 0; a < 3; a++) begin
            if (pipe_reg[N+3].neg[a] && (pipe_reg[N+3].rem[a] != '0)) begin
                pipe_next[N+4].rem[a] = pipe_reg[N+3].m[a] - pipe_reg[N+3].rem[a];
            end
        end
    end

    // rescale to coordinate units and pick the result of the cell kind
    always_comb begin : st_sel
        logic [OW-1:0]        lp_h;
        logic [OW-1:0]        t;
        logic signed [OW-1:0] ov;
        logic                 len_np;
        pipe_next[N+5] = pipe_reg[N+4];
        if (frame_reg.kind == KIND_NONE) begin
            pipe_next[N+5].in_cell = 1'b0;
        end
        for (int a = 0; a < 3; a++) begin
            lp_h   = pipe_reg[N+4].fold ? pipe_reg[N+4].m[a] : (pipe_reg[N+4].m[a] >> 1);
            t      = pipe_reg[N+4].fold ? (pipe_reg[N+4].rem[a] + HALF_LSB)
                                        : (pipe_reg[N+4].rem[a] - lp_h + ONE_LSB);
            ov     = pipe_reg[N+4].fold ? ($signed(t) >>> 10) : ($signed(t) >>> 11);
            len_np = frame_reg.lengths[a][ELEM_BITS-1] || (frame_reg.lengths[a] == '0);
            if (frame_reg.kind == KIND_PARA) begin
                pipe_next[N+5].rem[a] = OW'($signed(pipe_reg[N+4].pv[a]));
            end else if ((frame_reg.kind == KIND_NONE) || len_np) begin
                pipe_next[N+5].rem[a] = OW'($signed(pipe_reg[N+4].d[a]));
            end else begin
                pipe_next[N+5].rem[a] = ov;
            end
        end
    end

    // output stage: add r2 for minimum-image position, clamp
    always_comb begin : st_out
        logic signed [OW:0] v;
        pipe_next[LAST]     = pipe_reg[LAST-1];
        pipe_next[LAST].sat = 1'b0;
        for (int a = 0; a < 3; a++) begin
            v = (OW+1)'($signed(pipe_reg[LAST-1].rem[a]))
                + (pipe_reg[LAST-1].func1 ? (OW+1)'($signed(pipe_reg[LAST-1].r2[a]))
                                          : (OW+1)'(0));
            if (v > (OW+1)'(C_MAX)) begin
                pipe_next[LAST].res[a] = C_MAX;
                pipe_next[LAST].sat    = 1'b1;
            end else if (v < (OW+1)'(C_MIN)) begin
                pipe_next[LAST].res[a] = C_MIN;
                pipe_next[LAST].sat    = 1'b1;
            end else begin
                pipe_next[LAST].res[a] = v[CB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            frame_reg <= '0;
        end else begin
            frame_reg <= frame_next;
            if (adv) begin
                valid_reg <= valid_next;
            end
        end
        if (adv) begin
            for (int s = 0; s <= LAST; s++) begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    pmif_frac_path #(
        .COORD_BITS      (COORD_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_frac (
        .aclk       (aclk),
        .adv        (adv),
        .frame      (frame_reg),
        .fold_in    (pipe_reg[1].fold),
        .d_in       (pipe_reg[1].d),
        .r1_in      (pipe_reg[1].r1),
        .v_out      (frac_v),
        .inside_out (frac_inside)
    );

    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = OUT_TDATA'({pipe_reg[LAST].sat, pipe_reg[LAST].in_cell,
                                  pipe_reg[LAST].res});

    // ---- checks ----
    `PMIF_ASSERT_IMP(a_no_frame_not_inside, m_tvalid && (frame_reg.kind == KIND_NONE), !pipe_reg[LAST].in_cell, "inside flagged with no cell")
    `PMIF_ASSERT_IMP(a_sat_at_limit, m_tvalid && pipe_reg[LAST].sat, (pipe_reg[LAST].res[0] == C_MAX) || (pipe_reg[LAST].res[0] == C_MIN) || (pipe_reg[LAST].res[1] == C_MAX) || (pipe_reg[LAST].res[1] == C_MIN) || (pipe_reg[LAST].res[2] == C_MAX) || (pipe_reg[LAST].res[2] == C_MIN), "saturated without a clamped component")
    `PMIF_ASSERT_IMP(a_rem_below_mod, valid_reg[STEP_END] && ((frame_reg.kind == KIND_CUBIC) || (frame_reg.kind == KIND_ORTHO)) && !frame_reg.lengths[0][ELEM_BITS-1] && (frame_reg.lengths[0] != '0), pipe_reg[STEP_END].rem[0] < pipe_reg[STEP_END].m[0], "remainder chain left value above modulus")
    `PMIF_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, valid_reg[0], "accepted transfer lost at pipeline entry")

endmodule
